FILE: hdl/dwd_pkg.sv
// ----------------------------------------------------------------------------
// dwd_pkg
// shared sizes, request and status codes and the result word type of the
// bounded deque with delete by value
// ----------------------------------------------------------------------------
package dwd_pkg;

  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_DELETE     = 3'd2;
  localparam logic [2:0] REQ_LIST_FWD   = 3'd3;
  localparam logic [2:0] REQ_LIST_BWD   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic signed [31:0] item_value;
    logic              last;
  } dwd_emit_t;

endpackage

FILE: hdl/dwd_req_if.sv
// ----------------------------------------------------------------------------
// dwd_req_if
// request channel: one word carries a request type and a value
// ----------------------------------------------------------------------------
interface dwd_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

FILE: hdl/dwd_rsp_if.sv
// ----------------------------------------------------------------------------
// dwd_rsp_if
// result channel: one word carries status, listed value and last flag
// ----------------------------------------------------------------------------
interface dwd_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] item_value;
  logic               last;

  modport source (output valid, output status, output item_value, output last, input ready);
  modport sink   (input valid, input status, input item_value, input last, output ready);
endinterface

FILE: hdl/dwd_ram.sv
// ----------------------------------------------------------------------------
// dwd_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dwd_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/dwd_ctrl.sv
// ----------------------------------------------------------------------------
// dwd_ctrl
// request sequencer: pushes, pipelined search and compaction for delete,
// and listing reads paced by the output stage
// ----------------------------------------------------------------------------
module dwd_ctrl
  import dwd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  dwd_req_if.sink                in_ch,
  input  logic                   can_emit,
  output dwd_emit_t              emit,
  output logic                   ram_we,
  output logic [IDX_W-1:0]       ram_waddr,
  output logic [VALUE_WIDTH-1:0] ram_wdata,
  output logic                   ram_re,
  output logic [IDX_W-1:0]       ram_raddr,
  input  logic [VALUE_WIDTH-1:0] ram_rdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EMIT  = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_LIST  = 3'd4;

  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] f,
                                               input logic [CNT_W-1:0] p);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(f) + (CNT_W+1)'(p);
    if (s >= (CNT_W+1)'(CAPACITY)) begin
      s = s - (CNT_W+1)'(CAPACITY);
    end
    return IDX_W'(s);
  endfunction

  logic [2:0]             state_r, state_nxt;
  logic [IDX_W-1:0]       front_r, front_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       iss_r, iss_nxt;
  logic [CNT_W-1:0]       em_r, em_nxt;
  logic [CNT_W-1:0]       wpos_r, wpos_nxt;
  logic                   pend_r, pend_nxt;
  logic                   bwd_r, bwd_nxt;
  logic [1:0]             st_r, st_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;

  logic [VALUE_WIDTH-1:0] in_val;
  logic [IDX_W-1:0]       front_dec;
  logic [CNT_W-1:0]       list_pos;
  logic [CNT_W-1:0]       count_m1;
  logic                   issue;
  logic                   is_last;

  assign in_val    = VALUE_WIDTH'($unsigned(in_ch.value));
  assign front_dec = (front_r == '0) ? IDX_W'(CAPACITY - 1) : front_r - 1'b1;
  assign count_m1  = count_r - CNT_ONE;
  assign list_pos  = bwd_r ? (count_m1 - iss_r) : iss_r;
  assign is_last   = (em_r == count_m1);
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    count_nxt = count_r;
    iss_nxt   = iss_r;
    em_nxt    = em_r;
    wpos_nxt  = wpos_r;
    pend_nxt  = pend_r;
    bwd_nxt   = bwd_r;
    st_nxt    = st_r;
    val_nxt   = val_r;
    issue     = 1'b0;

    ram_we    = 1'b0;
    ram_waddr = slot_of(front_r, wpos_r);
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = slot_of(front_r, iss_r);

    emit.valid      = 1'b0;
    emit.status     = st_r;
    emit.item_value = '0;
    emit.last       = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          iss_nxt  = '0;
          em_nxt   = '0;
          pend_nxt = 1'b0;
          case (in_ch.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              state_nxt = S_EMIT;
              if (count_r == CNT_FULL) begin
                st_nxt = ST_FULL;
              end else begin
                st_nxt    = ST_OK;
                ram_we    = 1'b1;
                ram_wdata = in_val;
                count_nxt = count_r + CNT_ONE;
                if (in_ch.req_type == REQ_PUSH_FRONT) begin
                  front_nxt = front_dec;
                  ram_waddr = front_dec;
                end else begin
                  ram_waddr = slot_of(front_r, count_r);
                end
              end
            end
            REQ_DELETE: begin
              val_nxt = in_val;
              if (count_r == '0) begin
                st_nxt    = ST_NOT_FOUND;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            REQ_LIST_FWD, REQ_LIST_BWD: begin
              bwd_nxt = (in_ch.req_type == REQ_LIST_BWD);
              if (count_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_EMIT: begin
        emit.valid = 1'b1;
        if (can_emit) begin
          state_nxt = S_IDLE;
        end
      end

      S_SRCH: begin
        issue = (iss_r < count_r);
        if (issue) begin
          ram_re   = 1'b1;
          iss_nxt  = iss_r + CNT_ONE;
          wpos_nxt = iss_r - CNT_ONE;
        end
        pend_nxt = issue;
        if (pend_r) begin
          em_nxt = em_r + CNT_ONE;
          if (ram_rdata == val_r) begin
            state_nxt = S_SHIFT;
          end else if (is_last) begin
            st_nxt    = ST_NOT_FOUND;
            state_nxt = S_EMIT;
          end
        end
      end

      S_SHIFT: begin
        if (pend_r) begin
          ram_we = 1'b1;
        end
        issue = (iss_r < count_r);
        if (issue) begin
          ram_re   = 1'b1;
          iss_nxt  = iss_r + CNT_ONE;
          wpos_nxt = iss_r - CNT_ONE;
        end
        pend_nxt = issue;
        if (!pend_r && !issue) begin
          count_nxt = count_m1;
          st_nxt    = ST_OK;
          state_nxt = S_EMIT;
        end
      end

      S_LIST: begin
        ram_raddr = slot_of(front_r, list_pos);
        issue     = (iss_r < count_r) && (!pend_r || can_emit);
        if (issue) begin
          ram_re  = 1'b1;
          iss_nxt = iss_r + CNT_ONE;
        end
        if (pend_r) begin
          emit.valid      = 1'b1;
          emit.status     = ST_OK;
          emit.item_value = 32'(ram_rdata);
          emit.last       = is_last;
          if (can_emit) begin
            em_nxt = em_r + CNT_ONE;
            if (is_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
        pend_nxt = issue || (pend_r && !can_emit);
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r  <= iss_nxt;
    em_r   <= em_nxt;
    wpos_r <= wpos_nxt;
    bwd_r  <= bwd_nxt;
    st_r   <= st_nxt;
    val_r  <= val_nxt;
  end

endmodule

FILE: hdl/deque_with_delete_by_value_core.sv
// ----------------------------------------------------------------------------
// deque_with_delete_by_value_core
// bounded double-ended list of signed values with delete by value
// ----------------------------------------------------------------------------
// Requests are taken one at a time. Entries live in a circular store in a
// single ram with one write and one registered read port. A push is
// accepted, then its result word is emitted. A delete reads one entry per
// cycle from the front until it finds a match, then moves each later entry
// one place toward the front at one entry per cycle. A listing emits one
// word per cycle once started, when the result side does not stall.
// Results pass through an output register, so the next request is accepted
// while the last result word still waits to be taken.
module deque_with_delete_by_value_core
  import dwd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  dwd_req_if.sink in_ch,
  dwd_rsp_if.source out_ch
);

  dwd_emit_t              emit;
  logic                   can_emit;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic signed [31:0]     out_value_r;
  logic                   out_last_r;

  assign can_emit = !out_valid_r || out_ch.ready;

  dwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .can_emit  (can_emit),
    .emit      (emit),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  dwd_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_emit) begin
      out_valid_r <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit && emit.valid) begin
      out_status_r <= emit.status;
      out_value_r  <= emit.item_value;
      out_last_r   <= emit.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.item_value = out_value_r;
  assign out_ch.last       = out_last_r;

endmodule
